### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define BPTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define BPTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bptc_pkg.sv
// shared types, constants and arithmetic helpers of the barometer compensation core
`default_nettype none

package bptc_pkg;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // restoring divider depth, one quotient bit per stage
    localparam int DIV_STAGES = 64;

    // compensation constants
    localparam logic [33:0] TEMP_OFFSET  = 34'd128000;
    localparam logic [20:0] PRESS_OFFSET = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE  = 12'd3125;
    localparam logic [31:0] CENTI_ROUND  = 32'd128;
    localparam logic [63:0] V1_BIAS      = 64'h0000_8000_0000_0000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TEMP_CALIB  = 2'd0,
        REG_PRESS_LOW   = 2'd1,
        REG_PRESS_MID   = 2'd2,
        REG_PRESS_HIGH  = 2'd3
    } t_reg_idx;

    // unpacked calibration words
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_calib;

    // item handed from front to back
    typedef struct packed {
        logic [19:0] raw_p;
        logic [31:0] fine;
    } t_mid;

    // queue status
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    // front status
    typedef struct packed {
        logic last_valid;
        logic stall;
    } t_front_stat;

    // temperature results carried along the pressure path
    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
    } t_temp;

    // side data through the divider
    typedef struct packed {
        t_temp temp;
        logic  ok;
        logic  neg;
    } t_div_side;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    // unsigned 32 bit times signed 16 bit, full product
    function automatic logic [48:0] mul_u32_s16(input logic [31:0] a, input logic [15:0] b);
        logic signed [32:0] sa;
        logic signed [15:0] sb;
        logic signed [48:0] pr;
        sa = $signed({1'b0, a});
        sb = $signed(b);
        pr = sa * sb;
        return pr;
    endfunction

    // low 32 bits of a times sign-extended b
    function automatic logic [31:0] mul_lo32_s16(input logic [31:0] a, input logic [15:0] b);
        return a * {{16{b[15]}}, b};
    endfunction

    // join upper and lower partial products into a 64 bit wrap result
    function automatic logic [63:0] join_prod(input logic [31:0] hi, input logic [48:0] lo);
        return {hi, 32'd0} + {{15{lo[48]}}, lo};
    endfunction

endpackage

`default_nettype wire

### rtl/core/bptc_front.sv
// front: input capture and 32 bit temperature compensation pipeline
`default_nettype none

module bptc_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bptc_pkg::t_calib      i_calib,
    input  wire logic                  i_push,
    input  wire logic [19:0]           i_raw_t,
    input  wire logic [19:0]           i_raw_p,
    input  wire bptc_pkg::t_q_stat     i_q_stat,
    output logic                       o_full,
    output logic                       o_q_push,
    output bptc_pkg::t_mid             o_q_item,
    output bptc_pkg::t_front_stat      o_stat
);
    import bptc_pkg::*;

    logic        w_en;
    logic [3:0]  r_fv;
    logic [19:0] r_f0_t;
    logic [19:0] r_f0_p;
    logic [19:0] r_f1_p;
    logic [19:0] r_f2_p;
    logic [19:0] r_f3_p;
    logic [31:0] r_f1_prod;
    logic [31:0] r_f1_dd;
    logic [31:0] r_f2_tv1;
    logic [31:0] r_f2_x;
    logic [31:0] r_f3_fine;
    logic [31:0] w_a;
    logic [31:0] w_d;
    logic [31:0] w_t2;
    logic [31:0] w_t3;

    // stall only when the last stage cannot hand over
    assign w_en     = !(r_fv[3] && i_q_stat.full);
    assign o_full   = !w_en;
    assign o_q_push = r_fv[3] && !i_q_stat.full;
    assign o_q_item = '{raw_p: r_f3_p, fine: r_f3_fine};
    assign o_stat   = '{last_valid: r_fv[3], stall: !w_en};

    // calibration operands
    assign w_t2 = {{16{i_calib.t2[15]}}, i_calib.t2};
    assign w_t3 = {{16{i_calib.t3[15]}}, i_calib.t3};
    assign w_a  = {15'd0, r_f0_t[19:3]} - {15'd0, i_calib.t1, 1'b0};
    assign w_d  = {16'd0, r_f0_t[19:4]} - {16'd0, i_calib.t1};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[2:0], i_push};
        end
    end

    // temperature datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f0_t    <= i_raw_t;
            r_f0_p    <= i_raw_p;
            r_f1_prod <= w_a * w_t2;
            r_f1_dd   <= w_d * w_d;
            r_f1_p    <= r_f0_p;
            r_f2_tv1  <= asr32(r_f1_prod, 11);
            r_f2_x    <= asr32(r_f1_dd, 12) * w_t3;
            r_f2_p    <= r_f1_p;
            r_f3_fine <= r_f2_tv1 + asr32(r_f2_x, 14);
            r_f3_p    <= r_f2_p;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bptc_queue.sv
// short register queue decoupling front and back
`default_nettype none

module bptc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bptc_pkg::t_mid    i_item,
    input  wire logic              i_pop,
    output bptc_pkg::t_mid         o_item,
    output bptc_pkg::t_q_stat      o_stat
);
    import bptc_pkg::*;

    t_mid              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_item = r_mem[r_rp];
    assign o_stat = '{full: (r_cnt == QCNT_W'(QDEPTH)), empty: (r_cnt == '0), count: r_cnt};

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bptc_div.sv
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
`default_nettype none

module bptc_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [63:0]           i_num,
    input  wire logic [63:0]           i_den,
    input  wire bptc_pkg::t_div_side   i_side,
    output logic                       o_valid,
    output logic [63:0]                o_quot,
    output bptc_pkg::t_div_side        o_side
);
    import bptc_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [63:0]           r_rem  [DIV_STAGES];
    logic [63:0]           r_nq   [DIV_STAGES];
    logic [63:0]           r_den  [DIV_STAGES];
    t_div_side             r_side [DIV_STAGES];
    logic [63:0]           w_rem  [DIV_STAGES];
    logic [63:0]           w_nq   [DIV_STAGES];

    // shift in one dividend bit, subtract when it fits
    function automatic logic [127:0] div_step(input logic [63:0] rem, input logic [63:0] nq,
                                              input logic [63:0] den);
        logic [63:0] sh;
        logic [63:0] nx;
        sh = {rem[62:0], nq[63]};
        nx = {nq[62:0], 1'b0};
        if (sh >= den) begin
            sh    = sh - den;
            nx[0] = 1'b1;
        end
        return {sh, nx};
    endfunction

    // per-stage step logic
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                {w_rem[k], w_nq[k]} = div_step(64'd0, i_num, i_den);
            end else begin
                {w_rem[k], w_nq[k]} = div_step(r_rem[k-1], r_nq[k-1], r_den[k-1]);
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= w_rem[k];
                r_nq[k]  <= w_nq[k];
                if (k == 0) begin
                    r_den[k]  <= i_den;
                    r_side[k] <= i_side;
                end else begin
                    r_den[k]  <= r_den[k-1];
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_nq[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/bptc_back.sv
// back: 64 bit pressure compensation pipeline with divider and output register
`default_nettype none

module bptc_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bptc_pkg::t_calib      i_calib,
    input  wire bptc_pkg::t_mid        i_q_item,
    input  wire bptc_pkg::t_q_stat     i_q_stat,
    output logic                       o_q_pop,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output logic [31:0]                o_fine,
    output logic [31:0]                o_centi,
    output logic [31:0]                o_press,
    output logic                       o_press_valid
);
    import bptc_pkg::*;

    logic        w_en;
    logic        w_pop;
    logic [7:0]  r_bv;
    logic [5:0]  r_qv;
    logic        r_ov;

    // stage b0
    t_temp              r_b0_side;
    logic signed [33:0] r_b0_v1;
    logic [19:0]        r_b0_p;
    logic [31:0]        w_c;
    logic signed [33:0] w_v1;
    // stage b1
    t_temp              r_b1_side;
    logic [63:0]        r_b1_sq;
    logic [49:0]        r_b1_m5;
    logic [49:0]        r_b1_m2;
    logic [19:0]        r_b1_p;
    logic signed [67:0] w_sq;
    logic signed [49:0] w_m5;
    logic signed [49:0] w_m2;
    // stage b2
    t_temp              r_b2_side;
    logic [48:0]        r_b2_s6lo;
    logic [31:0]        r_b2_s6hi;
    logic [48:0]        r_b2_s3lo;
    logic [31:0]        r_b2_s3hi;
    logic [49:0]        r_b2_m5;
    logic [49:0]        r_b2_m2;
    logic [19:0]        r_b2_p;
    // stage b3
    t_temp              r_b3_side;
    logic [63:0]        r_b3_v2;
    logic [63:0]        r_b3_v1b;
    logic [19:0]        r_b3_p;
    // stage b4
    t_temp              r_b4_side;
    logic [63:0]        r_b4_x;
    logic [63:0]        r_b4_nd;
    logic [20:0]        w_pp;
    // stage b5
    t_temp              r_b5_side;
    logic [47:0]        r_b5_xlo;
    logic [31:0]        r_b5_xhi;
    logic [43:0]        r_b5_ndlo;
    logic [31:0]        r_b5_ndhi;
    // stage b6
    t_temp              r_b6_side;
    logic [63:0]        r_b6_den;
    logic [63:0]        r_b6_num;
    // stage b7
    t_div_side          r_b7_side;
    logic [63:0]        r_b7_mn;
    logic [63:0]        r_b7_md;
    // divider
    logic               w_div_valid;
    logic [63:0]        w_div_q;
    t_div_side          w_div_side;
    // stages q1..q6
    t_div_side          r_q1_side;
    logic [63:0]        r_q1_p;
    t_div_side          r_q2_side;
    logic [63:0]        r_q2_p;
    logic [63:0]        r_q2_ps;
    logic [48:0]        r_q2_a9lo;
    logic [31:0]        r_q2_a9hi;
    logic [48:0]        r_q2_w2lo;
    logic [31:0]        r_q2_w2hi;
    logic [63:0]        w_ps;
    t_div_side          r_q3_side;
    logic [63:0]        r_q3_p;
    logic [63:0]        r_q3_ps;
    logic [63:0]        r_q3_a9;
    logic [63:0]        r_q3_w2;
    t_div_side          r_q4_side;
    logic [63:0]        r_q4_p;
    logic [63:0]        r_q4_w2;
    logic [63:0]        r_q4_ll;
    logic [31:0]        r_q4_lh;
    logic [31:0]        r_q4_hl;
    t_div_side          r_q5_side;
    logic [63:0]        r_q5_p;
    logic [63:0]        r_q5_w2;
    logic [63:0]        r_q5_w1;
    t_div_side          r_q6_side;
    logic [63:0]        r_q6_sum;
    logic [31:0]        w_press;
    // output register
    logic [31:0]        r_o_fine;
    logic [31:0]        r_o_centi;
    logic [31:0]        r_o_press;
    logic               r_o_valid;

    // advance whenever the output register is free or being taken
    assign w_en    = !r_ov || i_pop;
    assign w_pop   = w_en && !i_q_stat.empty;
    assign o_q_pop = w_pop;
    assign o_empty = !r_ov;

    // combinational helpers per stage
    assign w_c   = {i_q_item.fine[29:0], 2'b00} + i_q_item.fine + CENTI_ROUND;
    assign w_v1  = $signed({{2{i_q_item.fine[31]}}, i_q_item.fine} - TEMP_OFFSET);
    assign w_sq  = r_b0_v1 * r_b0_v1;
    assign w_m5  = r_b0_v1 * $signed(i_calib.p5);
    assign w_m2  = r_b0_v1 * $signed(i_calib.p2);
    assign w_pp  = PRESS_OFFSET - {1'b0, r_b3_p};
    assign w_ps  = asr64(r_q1_p, 13);
    assign w_press = r_q6_sum[39:8] + {{12{i_calib.p7[15]}}, i_calib.p7, 4'd0};

    bptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_bv[7]),
        .i_num   (r_b7_mn),
        .i_den   (r_b7_md),
        .i_side  (r_b7_side),
        .o_valid (w_div_valid),
        .o_quot  (w_div_q),
        .o_side  (w_div_side)
    );

    // valid chains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_qv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_bv <= {r_bv[6:0], w_pop};
            r_qv <= {r_qv[4:0], w_div_valid};
            r_ov <= r_qv[5];
        end
    end

    // pressure datapath
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // centi temperature and v1
            r_b0_side <= '{fine: i_q_item.fine, centi: asr32(w_c, 8)};
            r_b0_v1   <= w_v1;
            r_b0_p    <= i_q_item.raw_p;
            // v1 square and linear terms
            r_b1_side <= r_b0_side;
            r_b1_sq   <= w_sq[63:0];
            r_b1_m5   <= w_m5;
            r_b1_m2   <= w_m2;
            r_b1_p    <= r_b0_p;
            // square times p6 and p3, split in halves
            r_b2_side <= r_b1_side;
            r_b2_s6lo <= mul_u32_s16(r_b1_sq[31:0], i_calib.p6);
            r_b2_s6hi <= mul_lo32_s16(r_b1_sq[63:32], i_calib.p6);
            r_b2_s3lo <= mul_u32_s16(r_b1_sq[31:0], i_calib.p3);
            r_b2_s3hi <= mul_lo32_s16(r_b1_sq[63:32], i_calib.p3);
            r_b2_m5   <= r_b1_m5;
            r_b2_m2   <= r_b1_m2;
            r_b2_p    <= r_b1_p;
            // var2 and var1 sums
            r_b3_side <= r_b2_side;
            r_b3_v2   <= join_prod(r_b2_s6hi, r_b2_s6lo)
                         + ({{14{r_b2_m5[49]}}, r_b2_m5} << 17)
                         + ({{48{i_calib.p4[15]}}, i_calib.p4} << 35);
            r_b3_v1b  <= asr64(join_prod(r_b2_s3hi, r_b2_s3lo), 8)
                         + ({{14{r_b2_m2[49]}}, r_b2_m2} << 12);
            r_b3_p    <= r_b2_p;
            // bias and numerator
            r_b4_side <= r_b3_side;
            r_b4_x    <= r_b3_v1b + V1_BIAS;
            r_b4_nd   <= {12'd0, w_pp, 31'd0} - r_b3_v2;
            // scale by p1 and by 3125, split in halves
            r_b5_side <= r_b4_side;
            r_b5_xlo  <= {16'd0, r_b4_x[31:0]} * {32'd0, i_calib.p1};
            r_b5_xhi  <= r_b4_x[63:32] * {16'd0, i_calib.p1};
            r_b5_ndlo <= {12'd0, r_b4_nd[31:0]} * {32'd0, PRESS_SCALE};
            r_b5_ndhi <= r_b4_nd[63:32] * {20'd0, PRESS_SCALE};
            // divisor and dividend
            r_b6_side <= r_b5_side;
            r_b6_den  <= asr64({r_b5_xhi, 32'd0} + {16'd0, r_b5_xlo}, 33);
            r_b6_num  <= {r_b5_ndhi, 32'd0} + {20'd0, r_b5_ndlo};
            // sign and magnitude
            r_b7_side <= '{temp: r_b6_side, ok: (r_b6_den != 64'd0),
                           neg: (r_b6_num[63] ^ r_b6_den[63])};
            r_b7_mn   <= r_b6_num[63] ? (64'd0 - r_b6_num) : r_b6_num;
            r_b7_md   <= r_b6_den[63] ? (64'd0 - r_b6_den) : r_b6_den;
            // quotient sign
            r_q1_side <= w_div_side;
            r_q1_p    <= w_div_side.neg ? (64'd0 - w_div_q) : w_div_q;
            // p9 and p8 partial products
            r_q2_side <= r_q1_side;
            r_q2_p    <= r_q1_p;
            r_q2_ps   <= w_ps;
            r_q2_a9lo <= mul_u32_s16(w_ps[31:0], i_calib.p9);
            r_q2_a9hi <= mul_lo32_s16(w_ps[63:32], i_calib.p9);
            r_q2_w2lo <= mul_u32_s16(r_q1_p[31:0], i_calib.p8);
            r_q2_w2hi <= mul_lo32_s16(r_q1_p[63:32], i_calib.p8);
            // join partials
            r_q3_side <= r_q2_side;
            r_q3_p    <= r_q2_p;
            r_q3_ps   <= r_q2_ps;
            r_q3_a9   <= join_prod(r_q2_a9hi, r_q2_a9lo);
            r_q3_w2   <= asr64(join_prod(r_q2_w2hi, r_q2_w2lo), 19);
            // p9*ps times ps, wrap product in three pieces
            r_q4_side <= r_q3_side;
            r_q4_p    <= r_q3_p;
            r_q4_w2   <= r_q3_w2;
            r_q4_ll   <= {32'd0, r_q3_a9[31:0]} * {32'd0, r_q3_ps[31:0]};
            r_q4_lh   <= r_q3_a9[31:0] * r_q3_ps[63:32];
            r_q4_hl   <= r_q3_a9[63:32] * r_q3_ps[31:0];
            // var1 of the final step
            r_q5_side <= r_q4_side;
            r_q5_p    <= r_q4_p;
            r_q5_w2   <= r_q4_w2;
            r_q5_w1   <= asr64(r_q4_ll + {r_q4_lh + r_q4_hl, 32'd0}, 25);
            // final sum
            r_q6_side <= r_q5_side;
            r_q6_sum  <= r_q5_p + r_q5_w1 + r_q5_w2;
            // output register
            r_o_fine  <= r_q6_side.temp.fine;
            r_o_centi <= r_q6_side.temp.centi;
            r_o_press <= r_q6_side.ok ? w_press : 32'd0;
            r_o_valid <= r_q6_side.ok;
        end
    end

    assign o_fine        = r_o_fine;
    assign o_centi       = r_o_centi;
    assign o_press       = r_o_press;
    assign o_press_valid = r_o_valid;

endmodule

`default_nettype wire

### rtl/core/barometric_pressure_temp_compensation_core.sv
// Path: front stages f0..f3, the queue, back stages b0..b7, the divider, q1..q6 and the output register.
// Throughput: one sample pair per cycle when not stalled; the 64-stage divider, one quotient bit per stage,
// sets the depth of the pressure pipeline.
// A 4-entry queue parts the temperature front from the pressure back; each stalls on its own.
// Reset (synchronous, active low) clears all valid bits, the queue and the calibration words.
`default_nettype none
`include "assert_macros.svh"

module barometric_pressure_temp_compensation_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // sample input
    input  wire logic         push,
    output logic              full,
    input  wire logic [19:0]  i_raw_temperature,
    input  wire logic [19:0]  i_raw_pressure,
    // result output
    output logic              empty,
    input  wire logic         pop,
    output logic [31:0]       o_fine_temperature,
    output logic [31:0]       o_temperature_centi,
    output logic [31:0]       o_pressure_q24_8,
    output logic              o_pressure_valid,
    // configuration write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import bptc_pkg::*;

    logic [47:0]  r_temp_calib;
    logic [63:0]  r_press_low;
    logic [63:0]  r_press_mid;
    logic [15:0]  r_press_high;
    t_calib       w_calib;
    logic         w_q_push;
    logic         w_q_pop;
    t_mid         w_q_in;
    t_mid         w_q_out;
    t_q_stat      w_q_stat;
    t_front_stat  w_front_stat;

    assign o_cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_low  <= '0;
            r_press_mid  <= '0;
            r_press_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TEMP_CALIB: r_temp_calib <= i_cfg_data[47:0];
                REG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                REG_PRESS_MID:  r_press_mid  <= i_cfg_data;
                REG_PRESS_HIGH: r_press_high <= i_cfg_data[15:0];
            endcase
        end
    end

    // unpack calibration words
    assign w_calib = '{
        t1: r_temp_calib[15:0],  t2: r_temp_calib[31:16], t3: r_temp_calib[47:32],
        p1: r_press_low[15:0],   p2: r_press_low[31:16],  p3: r_press_low[47:32],
        p4: r_press_low[63:48],  p5: r_press_mid[15:0],   p6: r_press_mid[31:16],
        p7: r_press_mid[47:32],  p8: r_press_mid[63:48],  p9: r_press_high
    };

    bptc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_calib  (w_calib),
        .i_push   (push && !full),
        .i_raw_t  (i_raw_temperature),
        .i_raw_p  (i_raw_pressure),
        .i_q_stat (w_q_stat),
        .o_full   (full),
        .o_q_push (w_q_push),
        .o_q_item (w_q_in),
        .o_stat   (w_front_stat)
    );

    bptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out),
        .o_stat  (w_q_stat)
    );

    bptc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_calib       (w_calib),
        .i_q_item      (w_q_out),
        .i_q_stat      (w_q_stat),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_fine        (o_fine_temperature),
        .o_centi       (o_temperature_centi),
        .o_press       (o_pressure_q24_8),
        .o_press_valid (o_pressure_valid)
    );

    // queue never overfills
    `BPTC_ASSERT(a_q_bound, i_clk, i_rst_n, w_q_stat.count <= QCNT_W'(QDEPTH), "queue overfilled")
    // front must refuse input while its last stage is blocked by a full queue
    `BPTC_ASSERT_IMP(a_front_stall, i_clk, i_rst_n, w_q_stat.full && w_front_stat.last_valid, full && w_front_stat.stall, "front not stalled")
    // a push without a pop grows the queue by one
    `BPTC_ASSERT_NXT(a_q_grow, i_clk, i_rst_n, w_q_push && !w_q_pop, w_q_stat.count == $past(w_q_stat.count) + 1'b1, "queue count lost a transfer")

endmodule

`default_nettype wire

### tb/tb_barometric_pressure_temp_compensation_core.sv
// testbench for the barometer integer compensation core: queue driver, monitor and predictor
`timescale 1ns / 1ps

module tb_barometric_pressure_temp_compensation_core;
    import bptc_pkg::*;

    localparam int MAX_CYCLES = 50000;
    localparam int N_PHASE    = 4;
    localparam int N_PER      = 275;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
    } t_sample;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] press;
        logic        ok;
    } t_comp;

    logic        i_clk;
    logic        i_rst_n;
    logic        push = 1'b0;
    wire         full;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    wire         empty;
    logic        pop = 1'b0;
    wire  [31:0] o_fine_temperature;
    wire  [31:0] o_temperature_centi;
    wire  [31:0] o_pressure_q24_8;
    wire         o_pressure_valid;
    logic        i_cfg_valid;
    wire         o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // calibration copy used by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_pmid;
    logic [15:0] cal_p9;

    t_sample sample_q[$];
    t_comp   comp_q[$];
    t_sample drv_s;
    t_comp   exp_c;
    int      mismatch_cnt;
    int      cycle_cnt;
    int      accepted_cnt;
    int      got_cnt;
    int      push_gap;
    int      pop_gap;
    bit      push_taken;
    bit      calm;

    barometric_pressure_temp_compensation_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_raw_temperature  (i_raw_temperature),
        .i_raw_pressure     (i_raw_pressure),
        .empty              (empty),
        .pop                (pop),
        .o_fine_temperature (o_fine_temperature),
        .o_temperature_centi(o_temperature_centi),
        .o_pressure_q24_8   (o_pressure_q24_8),
        .o_pressure_valid   (o_pressure_valid),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // arithmetic right shifts
    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // compensation predictor, 32-bit temperature and 64-bit pressure datapaths
    function automatic t_comp compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
        t_comp       r;
        logic [31:0] t1, t2, t3, a, d, tv1, tv2, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, den, p, num, mn, md, q, ps, w1, w2;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_plow[15:0]};
        p2 = {{48{cal_plow[31]}}, cal_plow[31:16]};
        p3 = {{48{cal_plow[47]}}, cal_plow[47:32]};
        p4 = {{48{cal_plow[63]}}, cal_plow[63:48]};
        p5 = {{48{cal_pmid[15]}}, cal_pmid[15:0]};
        p6 = {{48{cal_pmid[31]}}, cal_pmid[31:16]};
        p7 = {{48{cal_pmid[47]}}, cal_pmid[47:32]};
        p8 = {{48{cal_pmid[63]}}, cal_pmid[63:48]};
        p9 = {{48{cal_p9[15]}}, cal_p9};
        // temperature
        a    = {15'd0, raw_t[19:3]} - (t1 << 1);
        tv1  = sra32(a * t2, 11);
        d    = {16'd0, raw_t[19:4]} - t1;
        tv2  = sra32(sra32(d * d, 12) * t3, 14);
        fine = tv1 + tv2;
        r.fine  = fine;
        r.centi = sra32(fine * 32'd5 + 32'd128, 8);
        // pressure
        v1  = {{32{fine[31]}}, fine} - 64'd128000;
        v2  = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
        v1  = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        den = sra64(((64'd1 << 47) + v1) * p1, 33);
        r.press = 32'd0;
        r.ok    = 1'b0;
        if (den != 64'd0) begin
            p   = 64'd1048576 - {44'd0, raw_p};
            num = ((p << 31) - v2) * 64'd3125;
            mn  = num[63] ? (64'd0 - num) : num;
            md  = den[63] ? (64'd0 - den) : den;
            q   = mn / md;
            p   = (num[63] != den[63]) ? (64'd0 - q) : q;
            ps  = sra64(p, 13);
            w1  = sra64(p9 * ps * ps, 25);
            w2  = sra64(p8 * p, 19);
            p   = sra64(p + w1 + w2, 8) + (p7 << 4);
            r.press = p[31:0];
            r.ok    = 1'b1;
        end
        return r;
    endfunction

    // one raw sample pair, full range, near a typical reading or at the edges
    function automatic t_sample gen_sample();
        t_sample s;
        int      mode;
        mode = $urandom_range(0, 3);
        unique case (mode)
            1: begin
                s.raw_t = 20'(519888 + $urandom_range(0, 8191) - 4096);
                s.raw_p = 20'(415148 + $urandom_range(0, 8191) - 4096);
            end
            2: begin
                s.raw_t = ($urandom_range(0, 1) == 0) ? 20'h00000 : 20'hFFFFF;
                s.raw_p = ($urandom_range(0, 1) == 0) ? 20'h00000 : 20'hFFFFF;
            end
            default: begin
                s.raw_t = 20'($urandom);
                s.raw_p = 20'($urandom);
            end
        endcase
        return s;
    endfunction

    // one configuration transfer
    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        unique case (idx)
            REG_TEMP_CALIB: cal_temp = val[47:0];
            REG_PRESS_LOW:  cal_plow = val;
            REG_PRESS_MID:  cal_pmid = val;
            REG_PRESS_HIGH: cal_p9   = val[15:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // calibration set per phase: typical, random, zero divisor, extremes
    task automatic load_calib(input int ph);
        logic [63:0] w0, w1, w2, w3;
        unique case (ph)
            0: begin
                w0 = {16'd0, 16'hFC18, 16'h6743, 16'h6B70};
                w1 = {16'h0B27, 16'h0BD0, 16'hD643, 16'h8E7D};
                w2 = {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C};
                w3 = {48'd0, 16'h1770};
            end
            1: begin
                w0 = {$urandom, $urandom};
                w1 = {$urandom, $urandom};
                w2 = {$urandom, $urandom};
                w3 = {$urandom, $urandom};
            end
            2: begin
                w0 = {$urandom, $urandom};
                w1 = {$urandom, $urandom[31:16], 16'h0000};
                w2 = {$urandom, $urandom};
                w3 = {$urandom, $urandom};
            end
            default: begin
                w0 = {$urandom_range(0, 65535), 16'h7FFF, 16'h8000, 16'hFFFF};
                w1 = {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
                w2 = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
                w3 = {$urandom, $urandom[31:16], 16'h7FFF};
            end
        endcase
        cfg_write(REG_TEMP_CALIB, w0);
        cfg_write(REG_PRESS_LOW, w1);
        cfg_write(REG_PRESS_MID, w2);
        cfg_write(REG_PRESS_HIGH, w3);
    endtask

    // input driver: next item or an idle cycle at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            push_gap <= 0;
        end else if (!push || push_taken) begin
            if (push_gap > 0) begin
                push     <= 1'b0;
                push_gap <= push_gap - 1;
            end else if (sample_q.size() > 0) begin
                drv_s              = sample_q.pop_front();
                push              <= 1'b1;
                i_raw_temperature <= drv_s.raw_t;
                i_raw_pressure    <= drv_s.raw_p;
                if (!calm && ($urandom_range(0, 4) == 0)) begin
                    push_gap <= $urandom_range(1, 4);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result driver: pop with idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            pop_gap <= 0;
        end else if (pop_gap > 0) begin
            pop     <= 1'b0;
            pop_gap <= pop_gap - 1;
        end else begin
            pop <= 1'b1;
            if (!calm && ($urandom_range(0, 4) == 0)) begin
                pop_gap <= $urandom_range(1, 4);
            end
        end
    end

    // input monitor and predictor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push_taken <= 1'b0;
        end else begin
            push_taken <= push && !full;
            if (push && !full) begin
                comp_q.push_back(compensate(i_raw_temperature, i_raw_pressure));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            got_cnt <= got_cnt + 1;
            if (comp_q.size() == 0) begin
                if (mismatch_cnt < MAX_SHOWN) begin
                    $display("unexpected result: fine %h centi %h press %h ok %b",
                             o_fine_temperature, o_temperature_centi,
                             o_pressure_q24_8, o_pressure_valid);
                end
                mismatch_cnt <= mismatch_cnt + 1;
            end else begin
                exp_c = comp_q.pop_front();
                if (exp_c !== {o_fine_temperature, o_temperature_centi,
                               o_pressure_q24_8, o_pressure_valid}) begin
                    if (mismatch_cnt < MAX_SHOWN) begin
                        $display("mismatch: exp fine %h centi %h press %h ok %b",
                                 exp_c.fine, exp_c.centi, exp_c.press, exp_c.ok);
                        $display("          got fine %h centi %h press %h ok %b",
                                 o_fine_temperature, o_temperature_centi,
                                 o_pressure_q24_8, o_pressure_valid);
                    end
                    mismatch_cnt <= mismatch_cnt + 1;
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // reset, calibration phases and end of run
    initial begin
        int target;
        target      = 0;
        calm        = 1'b0;
        cal_temp    = '0;
        cal_plow    = '0;
        cal_pmid    = '0;
        cal_p9      = '0;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_TEMP_CALIB;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASE; ph++) begin
            load_calib(ph);
            calm = (ph == N_PHASE - 1);
            for (int n = 0; n < N_PER; n++) begin
                sample_q.push_back(gen_sample());
            end
            target = target + N_PER;
            // wait until every item of the phase has come out
            while (accepted_cnt != target || got_cnt != target) @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### barometric_pressure_temp_compensation_core.f
+incdir+rtl/core
rtl/core/bptc_pkg.sv
rtl/core/bptc_front.sv
rtl/core/bptc_queue.sv
rtl/core/bptc_div.sv
rtl/core/bptc_back.sv
rtl/core/barometric_pressure_temp_compensation_core.sv
tb/tb_barometric_pressure_temp_compensation_core.sv
